>>> rtl/entity_slot_allocator_unit_assert.svh
// assertion macros for the entity slot allocator
// no dependencies; included by entity_slot_allocator_unit to check its own logic
`ifndef ENTITY_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define ENTITY_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ESA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ESA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/esa_pkg.sv
// shared types and codes of the entity slot allocator
// no dependencies; imported by entity_slot_allocator_unit
package esa_pkg;

   // request codes
   typedef enum logic [2:0] {
      OP_CREATE     = 3'd0,
      OP_DESTROY    = 3'd1,
      OP_IS_DEAD    = 3'd2,
      OP_ADD_BITS   = 3'd3,
      OP_REMOVE_BITS = 3'd4,
      OP_HAS_BITS   = 3'd5,
      OP_FIND_FIRST = 3'd6,
      OP_CLEANUP    = 3'd7
   } op_code_type;

   // slot life states
   typedef logic [1:0] life_code_type;
   localparam life_code_type LIFE_ALIVE  = 2'd0;
   localparam life_code_type LIFE_MARKED = 2'd1;
   localparam life_code_type LIFE_FREED  = 2'd2;

   // response status codes
   typedef logic [1:0] status_code_type;
   localparam status_code_type STAT_OK   = 2'd0;
   localparam status_code_type STAT_FULL = 2'd1;
   localparam status_code_type STAT_NONE = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FINISH
   } seq_state_type;

endpackage

>>> rtl/entity_slot_allocator_unit.sv
// entity slot allocator: slot table, free queue and request sequencer
// depends on esa_pkg and entity_slot_allocator_unit_assert.svh
//
// Usage:
//   One request transaction enters on the req_ channel (req_valid/req_stall)
//   and exactly one response transaction leaves on the rsp_ channel
//   (rsp_valid/rsp_stall). req_stall is high while a request is in work.
//   Create, destroy, is_dead and the mask operations read the slot memory
//   in the accept cycle and finish in the execute state, which loads the
//   response into the output register once that register is free.
//   find_first and cleanup walk the slot memory one slot per cycle through
//   its single read port, from slot 0 up to the last slot ever taken
//   (find_first stops at the first hit).
//   The response sits in an output register; when the receiver stalls,
//   the sequencer holds the finished result and keeps req_stall high
//   until the output register can take it.
//   Reset (synchronous, active high) clears the counters, the queue
//   pointers and the handshake state at once; the slot and queue memories
//   are not cleared, as no entry is used before it is written.
module entity_slot_allocator_unit
   import esa_pkg::*;
#(
   parameter int MAX_SLOTS = 256,
   parameter int MASK_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_slot_id,
   input  logic [15:0] req_component_mask,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_result_slot,
   output logic        rsp_answer,
   output logic [8:0]  rsp_live_total
);

`include "entity_slot_allocator_unit_assert.svh"

   localparam int SW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int XW = (CW > 8) ? CW : 8;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SLOTS - 1);

   // pointer step with wrap at the table size
   function automatic logic [SW-1:0] ptr_step(input logic [SW-1:0] ptr);
      logic [SW-1:0] nxt;
      if (ptr == LAST_SLOT) nxt = '0;
      else nxt = ptr + SW'(1);
      return nxt;
   endfunction

   // memories
   life_code_type        life_mem  [MAX_SLOTS];
   logic [MASK_BITS-1:0] mask_mem  [MAX_SLOTS];
   logic [SW-1:0]        queue_mem [MAX_SLOTS];

   // control registers
   seq_state_type   state_ff, state_in;
   logic [CW-1:0]   fresh_count_ff, fresh_count_in;
   logic [SW-1:0]   queue_head_ff, queue_head_in;
   logic [SW-1:0]   queue_tail_ff, queue_tail_in;
   logic [CW-1:0]   queue_fill_ff, queue_fill_in;
   logic [CW-1:0]   live_count_ff, live_count_in;
   logic [SW-1:0]   scan_idx_ff, scan_idx_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // request and result holding registers
   op_code_type          op_ff;
   logic [SW-1:0]        idx_ff;
   logic                 sid_ok_ff;
   logic [MASK_BITS-1:0] want_ff;
   status_code_type      res_status_ff, res_status_in;
   logic [SW-1:0]        res_slot_ff, res_slot_in;
   logic                 res_answer_ff, res_answer_in;

   // memory read data
   life_code_type        life_rd_ff;
   logic [MASK_BITS-1:0] mask_rd_ff;
   logic [SW-1:0]        queue_rd_ff;

   // output register
   status_code_type rsp_status_ff;
   logic [7:0]      rsp_result_slot_ff;
   logic            rsp_answer_ff;
   logic [8:0]      rsp_live_total_ff;

   // combinational controls
   logic                 accept;
   logic                 out_free;
   logic                 load_out;
   status_code_type      out_status;
   logic [SW-1:0]        out_slot;
   logic                 out_answer;
   logic [CW-1:0]        out_live;
   logic                 rd_en;
   logic [SW-1:0]        rd_addr;
   logic                 life_we;
   logic [SW-1:0]        life_wa;
   life_code_type        life_wd;
   logic                 mask_we;
   logic [SW-1:0]        mask_wa;
   logic [MASK_BITS-1:0] mask_wd;
   logic                 queue_we;
   logic                 scan_last;
   logic                 scan_hit;
   op_code_type          req_op;
   logic                 req_is_scan;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_op      = op_code_type'(req_type);
   assign req_is_scan = (req_op == OP_FIND_FIRST) || (req_op == OP_CLEANUP);
   assign scan_last   = ((CW'(scan_idx_ff) + CW'(1)) == fresh_count_ff);
   assign scan_hit    = (life_rd_ff == LIFE_ALIVE) && ((mask_rd_ff & want_ff) == want_ff);

   // sequencer: next state, memory writes, counter updates, result load
   always_comb begin
      state_in       = state_ff;
      fresh_count_in = fresh_count_ff;
      queue_head_in  = queue_head_ff;
      queue_tail_in  = queue_tail_ff;
      queue_fill_in  = queue_fill_ff;
      live_count_in  = live_count_ff;
      scan_idx_in    = scan_idx_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_answer_in  = res_answer_ff;
      life_we        = 1'b0;
      life_wa        = idx_ff;
      life_wd        = LIFE_ALIVE;
      mask_we        = 1'b0;
      mask_wa        = idx_ff;
      mask_wd        = '0;
      queue_we       = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = SW'(req_slot_id);
      load_out       = 1'b0;
      out_status     = STAT_OK;
      out_slot       = '0;
      out_answer     = 1'b0;
      out_live       = live_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rd_en = 1'b1;
               if (req_is_scan) begin
                  rd_addr     = '0;
                  scan_idx_in = '0;
                  if (fresh_count_ff == '0) begin
                     // empty table: nothing to walk
                     res_status_in = (req_op == OP_FIND_FIRST) ? STAT_NONE : STAT_OK;
                     res_slot_in   = '0;
                     res_answer_in = 1'b0;
                     state_in      = ST_FINISH;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
               unique case (op_ff)
                  OP_CREATE: begin
                     if (queue_fill_ff != '0) begin
                        // reuse oldest freed slot, mask kept
                        out_slot      = queue_rd_ff;
                        life_we       = 1'b1;
                        life_wa       = queue_rd_ff;
                        queue_head_in = ptr_step(queue_head_ff);
                        queue_fill_in = queue_fill_ff - CW'(1);
                        live_count_in = live_count_ff + CW'(1);
                     end else if (fresh_count_ff != MAX_C) begin
                        // fresh slot with cleared mask
                        out_slot       = SW'(fresh_count_ff);
                        life_we        = 1'b1;
                        life_wa        = SW'(fresh_count_ff);
                        mask_we        = 1'b1;
                        mask_wa        = SW'(fresh_count_ff);
                        fresh_count_in = fresh_count_ff + CW'(1);
                        live_count_in  = live_count_ff + CW'(1);
                     end else begin
                        out_status = STAT_FULL;
                     end
                  end
                  OP_DESTROY: begin
                     if (!sid_ok_ff || (life_rd_ff == LIFE_FREED)) begin
                        out_status = STAT_NONE;
                     end else begin
                        life_we = 1'b1;
                        life_wd = LIFE_MARKED;
                     end
                  end
                  OP_IS_DEAD: begin
                     if (!sid_ok_ff) begin
                        out_status = STAT_NONE;
                        out_answer = 1'b1;
                     end else begin
                        out_answer = (life_rd_ff != LIFE_ALIVE);
                     end
                  end
                  OP_ADD_BITS: begin
                     if (!sid_ok_ff) begin
                        out_status = STAT_NONE;
                     end else begin
                        mask_we = 1'b1;
                        mask_wd = mask_rd_ff | want_ff;
                     end
                  end
                  OP_REMOVE_BITS: begin
                     if (!sid_ok_ff) begin
                        out_status = STAT_NONE;
                     end else begin
                        mask_we = 1'b1;
                        mask_wd = mask_rd_ff & ~want_ff;
                     end
                  end
                  OP_HAS_BITS: begin
                     if (!sid_ok_ff) out_status = STAT_NONE;
                     else out_answer = ((mask_rd_ff & want_ff) == want_ff);
                  end
                  default: begin
                     // scan requests never pass through execute
                  end
               endcase
               out_live = live_count_in;
            end
         end

         ST_SCAN: begin
            // one slot per cycle: data for scan_idx, read ahead at the next slot
            rd_en   = 1'b1;
            rd_addr = scan_idx_ff + SW'(1);
            if (op_ff == OP_FIND_FIRST) begin
               if (scan_hit) begin
                  res_status_in = STAT_OK;
                  res_slot_in   = scan_idx_ff;
                  res_answer_in = 1'b0;
                  state_in      = ST_FINISH;
               end else if (scan_last) begin
                  res_status_in = STAT_NONE;
                  res_slot_in   = '0;
                  res_answer_in = 1'b0;
                  state_in      = ST_FINISH;
               end else begin
                  scan_idx_in = scan_idx_ff + SW'(1);
               end
            end else begin
               if (life_rd_ff == LIFE_MARKED) begin
                  // free the slot and queue it
                  life_we = 1'b1;
                  life_wa = scan_idx_ff;
                  life_wd = LIFE_FREED;
                  if (queue_fill_ff != MAX_C) begin
                     queue_we      = 1'b1;
                     queue_tail_in = ptr_step(queue_tail_ff);
                     queue_fill_in = queue_fill_ff + CW'(1);
                  end
                  if (live_count_ff != '0) live_count_in = live_count_ff - CW'(1);
               end
               if (scan_last) begin
                  res_status_in = STAT_OK;
                  res_slot_in   = '0;
                  res_answer_in = 1'b0;
                  state_in      = ST_FINISH;
               end else begin
                  scan_idx_in = scan_idx_ff + SW'(1);
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               load_out   = 1'b1;
               out_status = res_status_ff;
               out_slot   = res_slot_ff;
               out_answer = res_answer_ff;
               out_live   = live_count_ff;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

   // response handshake
   always_comb begin
      if (load_out) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fresh_count_ff <= '0;
         queue_head_ff  <= '0;
         queue_tail_ff  <= '0;
         queue_fill_ff  <= '0;
         live_count_ff  <= '0;
         scan_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fresh_count_ff <= fresh_count_in;
         queue_head_ff  <= queue_head_in;
         queue_tail_ff  <= queue_tail_in;
         queue_fill_ff  <= queue_fill_in;
         live_count_ff  <= live_count_in;
         scan_idx_ff    <= scan_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // request capture and result holding
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         idx_ff    <= SW'(req_slot_id);
         sid_ok_ff <= (XW'(req_slot_id) < XW'(fresh_count_ff));
         want_ff   <= MASK_BITS'(req_component_mask);
      end
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_answer_ff <= res_answer_in;
      if (load_out) begin
         rsp_status_ff      <= out_status;
         rsp_result_slot_ff <= 8'(out_slot);
         rsp_answer_ff      <= out_answer;
         rsp_live_total_ff  <= 9'(out_live);
      end
   end

   // slot life state memory
   always_ff @(posedge clock) begin
      if (life_we) life_mem[life_wa] <= life_wd;
      if (rd_en) life_rd_ff <= life_mem[rd_addr];
   end

   // component mask memory
   always_ff @(posedge clock) begin
      if (mask_we) mask_mem[mask_wa] <= mask_wd;
      if (rd_en) mask_rd_ff <= mask_mem[rd_addr];
   end

   // free slot queue memory
   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[queue_tail_ff] <= scan_idx_ff;
      if (accept) queue_rd_ff <= queue_mem[queue_head_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_slot = rsp_result_slot_ff;
   assign rsp_answer      = rsp_answer_ff;
   assign rsp_live_total  = rsp_live_total_ff;

   // checks
   `ESA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != ST_IDLE,
      "accepted transaction did not start work")
   `ESA_ASSERT_NOW(a_load_only_when_free, clock, reset, load_out,
      !rsp_valid_ff || !rsp_stall, "response overwritten while stalled")
   `ESA_ASSERT_NOW(a_slot_accounting, clock, reset, 1'b1,
      ((CW+1)'(live_count_ff) + (CW+1)'(queue_fill_ff)) == (CW+1)'(fresh_count_ff),
      "live and queued slots do not add up to slots taken")
   `ESA_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == ST_SCAN,
      CW'(scan_idx_ff) < fresh_count_ff, "scan index past last taken slot")

endmodule
